### src/tpla_pkg.sv
`timescale 1ns / 1ps
package tpla_pkg;

  localparam int CoordWidthDef = 28;
  localparam int RangeWidthDef = 48;

  localparam logic [15:0] BaseScaleReset = 16'd18204;

  localparam logic [1:0] LayerBaseLo = 2'd1;
  localparam logic [1:0] LayerBaseHi = 2'd2;

  localparam int SumWidth   = 64;
  localparam int RootWidth  = SumWidth / 2;
  localparam int RootSteps  = RootWidth;
  localparam int CountWidth = $clog2(RootSteps);

  // square pipeline: three squares, one extra beat to fold in the last one
  localparam logic [1:0] SqLast = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic       scale;
    logic       sq_en;
    logic [1:0] sq_idx;
    logic       root_step;
    logic       base;
    logic       acc;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic add;
  } sts_t;

endpackage

### src/tpla_ctrl.sv
`timescale 1ns / 1ps
module tpla_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  tpla_pkg::sts_t sts_i,
  output tpla_pkg::cmd_t cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StScale  = 3'd1;
  localparam logic [2:0] StSquare = 3'd2;
  localparam logic [2:0] StRoot   = 3'd3;
  localparam logic [2:0] StBase   = 3'd4;
  localparam logic [2:0] StAccum  = 3'd5;
  localparam logic [2:0] StWrite  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [tpla_pkg::CountWidth-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.sq_idx = cnt_q[1:0];
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = sts_i.add ? StScale : StWrite;
        end
      end
      StScale: begin
        cmd_o.scale = 1'b1;
        cnt_d   = '0;
        state_d = StSquare;
      end
      StSquare: begin
        cmd_o.sq_en = 1'b1;
        if (cnt_q[1:0] == tpla_pkg::SqLast) begin
          cnt_d   = '0;
          state_d = StRoot;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StRoot: begin
        cmd_o.root_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == tpla_pkg::CountWidth'(tpla_pkg::RootSteps - 1)) begin
          state_d = StBase;
        end
      end
      StBase: begin
        cmd_o.base = 1'b1;
        state_d = StAccum;
      end
      StAccum: begin
        cmd_o.acc = 1'b1;
        state_d = StWrite;
      end
      StWrite: begin
        // hold the result until the output slot frees up
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### src/tpla_datapath.sv
`timescale 1ns / 1ps
module tpla_datapath #(
  parameter int CoordWidth = tpla_pkg::CoordWidthDef,
  parameter int RangeWidth = tpla_pkg::RangeWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic                  first_point_i,
  input  logic [7:0]            plate_number_i,
  input  logic [1:0]            layer_code_i,
  input  logic [CoordWidth-1:0] pos_x_i,
  input  logic [CoordWidth-1:0] pos_y_i,
  input  logic [CoordWidth-1:0] pos_z_i,
  input  logic [15:0]           shrink_index_i,
  input  tpla_pkg::cmd_t        cmd_i,
  output tpla_pkg::sts_t        sts_o,
  output logic [RangeWidth-1:0] range_total_o,
  output logic                  range_saturated_o
);

  localparam int MagW  = CoordWidth + 1;
  localparam int ZW    = MagW + 5;
  localparam int OpW   = (ZW > 33) ? ZW : 33;
  localparam int SumW  = tpla_pkg::SumWidth;
  localparam int RootW = tpla_pkg::RootWidth;
  localparam int RemW  = RootW + 3;

  // architectural state
  logic [15:0]           base_scale_q;
  logic [7:0]            prev_plate_q;
  logic [1:0]            prev_layer_q;
  logic [CoordWidth-1:0] prev_x_q, prev_y_q, prev_z_q;
  logic                  have_prev_q;
  logic [RangeWidth-1:0] range_q;
  logic                  sat_flag_q;

  // per-item working registers
  logic [MagW-1:0]  mx_q, my_q;
  logic [ZW-1:0]    mz_q;
  logic [15:0]      shrink_q;
  logic             base_q;
  logic             sat_work_q;
  logic [SumW-1:0]  sq_q, sum_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [RootW-1:0] dist_q;
  logic [RangeWidth-1:0] res_range_q;
  logic                  res_sat_q;

  logic signed [MagW-1:0] dx_s, dy_s, dz_s;
  logic [MagW-1:0]        mx_n, my_n, mz_n;
  logic                   base_n;
  logic [MagW+15:0]       zprod;
  logic [MagW+16:0]       zround;
  logic [OpW-1:0]         sq_op;
  logic                   sq_ovf;
  logic [SumW:0]          sum_add;
  logic [RemW-1:0]        rem_n, trial;
  logic                   take;
  logic [RootW+15:0]      bprod;
  logic [RootW+16:0]      bround;
  logic [RangeWidth:0]    range_add;

  assign sts_o.add = !first_point_i && have_prev_q && (plate_number_i == prev_plate_q);

  always_comb begin
    dx_s = $signed({pos_x_i[CoordWidth-1], pos_x_i}) - $signed({prev_x_q[CoordWidth-1], prev_x_q});
    dy_s = $signed({pos_y_i[CoordWidth-1], pos_y_i}) - $signed({prev_y_q[CoordWidth-1], prev_y_q});
    dz_s = $signed({pos_z_i[CoordWidth-1], pos_z_i}) - $signed({prev_z_q[CoordWidth-1], prev_z_q});
    mx_n = dx_s[MagW-1] ? MagW'(-dx_s) : MagW'(dx_s);
    my_n = dy_s[MagW-1] ? MagW'(-dy_s) : MagW'(dy_s);
    mz_n = dz_s[MagW-1] ? MagW'(-dz_s) : MagW'(dz_s);
    base_n = ((layer_code_i == tpla_pkg::LayerBaseLo) && (prev_layer_q == tpla_pkg::LayerBaseHi))
          || ((layer_code_i == tpla_pkg::LayerBaseHi) && (prev_layer_q == tpla_pkg::LayerBaseLo));
  end

  // dz shrink correction, round half up on the magnitude
  always_comb begin
    zprod  = mz_q[MagW-1:0] * shrink_q;
    zround = {1'b0, zprod} + (MagW+17)'(2048);
  end

  always_comb begin
    case (cmd_i.sq_idx)
      2'd0:    sq_op = OpW'(mx_q);
      2'd1:    sq_op = OpW'(my_q);
      default: sq_op = OpW'(mz_q);
    endcase
    sq_ovf  = |sq_op[OpW-1:32];
    sum_add = {1'b0, sum_q} + {1'b0, sq_q};
  end

  // one result bit per step: two radicand bits shift into the remainder
  always_comb begin
    rem_n = {rem_q[RemW-3:0], sum_q[SumW-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};
    take  = (rem_n >= trial);
  end

  always_comb begin
    bprod     = root_q * base_scale_q;
    bround    = {1'b0, bprod} + (RootW+17)'(32768);
    range_add = {1'b0, range_q} + (RangeWidth+1)'(dist_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_scale_q <= tpla_pkg::BaseScaleReset;
      prev_plate_q <= '0;
      prev_layer_q <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      prev_z_q     <= '0;
      have_prev_q  <= 1'b0;
      range_q      <= '0;
      sat_flag_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_scale_q <= cfg_wdata_i;
      end
      if (cmd_i.load_in) begin
        prev_plate_q <= plate_number_i;
        prev_layer_q <= layer_code_i;
        prev_x_q     <= pos_x_i;
        prev_y_q     <= pos_y_i;
        prev_z_q     <= pos_z_i;
        have_prev_q  <= 1'b1;
        if (first_point_i) begin
          range_q    <= '0;
          sat_flag_q <= 1'b0;
        end
      end
      if (cmd_i.acc) begin
        if (range_add[RangeWidth]) begin
          range_q <= '1;
        end else begin
          range_q <= range_add[RangeWidth-1:0];
        end
        sat_flag_q <= sat_flag_q | sat_work_q | range_add[RangeWidth];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mx_q       <= mx_n;
      my_q       <= my_n;
      mz_q       <= ZW'(mz_n);
      shrink_q   <= shrink_index_i;
      base_q     <= base_n;
      sat_work_q <= 1'b0;
    end
    if (cmd_i.scale) begin
      if (!base_q) begin
        mz_q <= zround[MagW+16:12];
      end
      sum_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.sq_en) begin
      // fold in the square from the previous beat, then start the next one
      if (cmd_i.sq_idx != 2'd0) begin
        if (sum_add[SumW]) begin
          sum_q <= '1;
        end else begin
          sum_q <= sum_add[SumW-1:0];
        end
      end
      if (cmd_i.sq_idx != tpla_pkg::SqLast) begin
        if (sq_ovf) begin
          sq_q <= '1;
        end else begin
          sq_q <= sq_op[31:0] * sq_op[31:0];
        end
      end
      sat_work_q <= sat_work_q
                  | ((cmd_i.sq_idx != 2'd0) && sum_add[SumW])
                  | ((cmd_i.sq_idx != tpla_pkg::SqLast) && sq_ovf);
    end
    if (cmd_i.root_step) begin
      sum_q  <= {sum_q[SumW-3:0], 2'b00};
      rem_q  <= take ? (rem_n - trial) : rem_n;
      root_q <= {root_q[RootW-2:0], take};
    end
    if (cmd_i.base) begin
      dist_q <= base_q ? bround[RootW+15:16] : root_q;
    end
    if (cmd_i.load_out) begin
      res_range_q <= range_q;
      res_sat_q   <= sat_flag_q;
    end
  end

  assign range_total_o     = res_range_q;
  assign range_saturated_o = res_sat_q;

endmodule

### src/track_path_length_accumulator.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Payload
// cfg      in         cfg_we_i                  cfg_wdata_i (base_scale, Q0.16)
// in       in         in_valid_i / in_stall_o   first_point_i .. shrink_index_i
// out      out        out_valid_o / out_stall_i range_total_o, range_saturated_o
//
// A point that adds a distance passes from accept to result through: accept,
// dz scale, 4 square/sum beats, 32 square-root steps (one root bit each),
// base scale, accumulate, write. Other points go from accept straight to write.
// One item is in work at a time; the next beat is taken while a result waits.
// Reset clears the previous point, the range and the flag; base_scale = 18204.
// A stalled output holds the block in its write step until the slot frees.
module track_path_length_accumulator #(
  parameter int CoordWidth = tpla_pkg::CoordWidthDef,
  parameter int RangeWidth = tpla_pkg::RangeWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  first_point_i,
  input  logic [7:0]            plate_number_i,
  input  logic [1:0]            layer_code_i,
  input  logic [CoordWidth-1:0] pos_x_i,
  input  logic [CoordWidth-1:0] pos_y_i,
  input  logic [CoordWidth-1:0] pos_z_i,
  input  logic [15:0]           shrink_index_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [RangeWidth-1:0] range_total_o,
  output logic                  range_saturated_o
);

  tpla_pkg::cmd_t cmd;
  tpla_pkg::sts_t sts;

  tpla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tpla_datapath #(
    .CoordWidth (CoordWidth),
    .RangeWidth (RangeWidth)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .first_point_i     (first_point_i),
    .plate_number_i    (plate_number_i),
    .layer_code_i      (layer_code_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .pos_z_i           (pos_z_i),
    .shrink_index_i    (shrink_index_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .range_total_o     (range_total_o),
    .range_saturated_o (range_saturated_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted beat did not make the block busy");

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_valid_o && out_stall_i))
    else $error("result loaded over a stalled beat");

  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_in, cmd.scale, cmd.sq_en, cmd.root_step, cmd.base, cmd.acc,
              cmd.load_out}))
    else $error("more than one datapath command at once");

  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_in |-> (in_valid_i && !in_stall_o))
    else $error("input loaded without a beat");

endmodule
